### src/fta_pkg.sv
// Shared types and constants for the fixed timestep accumulator.
package fta_pkg;

    localparam int DATA_W     = 32;
    localparam int QUO_W      = DATA_W + 1;
    localparam int STEPS_W    = 13;
    localparam int ALPHA_W    = 16;
    localparam int DIV_STEPS  = QUO_W;
    localparam int FRAC_STEPS = ALPHA_W;
    localparam int CNT_W      = $clog2(DIV_STEPS);

    localparam logic [1:0] MODE_ADVANCE = 2'd0;
    localparam logic [1:0] MODE_QUEUE   = 2'd1;
    localparam logic [1:0] MODE_CLEAR   = 2'd2;

    localparam logic [1:0] CFG_FIXED_STEP = 2'd0;
    localparam logic [1:0] CFG_MAX_FRAME  = 2'd1;
    localparam logic [1:0] CFG_PAUSE      = 2'd2;

    localparam logic [STEPS_W-1:0] STEPS_MAX = {STEPS_W{1'b1}};
    localparam logic [ALPHA_W-1:0] ALPHA_MAX = {ALPHA_W{1'b1}};

    typedef struct packed {
        logic [DATA_W-1:0] fixed_step;
        logic [DATA_W-1:0] max_frame;
        logic              pause;
        logic              ok;
    } cfg_t;

    typedef struct packed {
        logic              load;
        logic              iterate;
        logic              compare;
        logic [DATA_W-1:0] load_rem;
        logic [QUO_W-1:0]  load_quo;
    } divu_cmd_t;

    typedef struct packed {
        logic [DATA_W-1:0] rem;
        logic [QUO_W-1:0]  quo;
        logic              ge;
    } divu_stat_t;

endpackage

### src/fta_cfg.sv
// Configuration registers and the validity check of the step settings.
module fta_cfg #(
    parameter int STEP_LIMIT = 4096
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_we,
    input  logic [1:0]                cfg_index,
    input  logic [fta_pkg::DATA_W-1:0] cfg_data,
    output fta_pkg::cfg_t             cfg
);

    localparam int LIMIT_W = fta_pkg::DATA_W + $clog2(STEP_LIMIT + 1);

    logic [fta_pkg::DATA_W-1:0] fixed_step_reg;
    logic [fta_pkg::DATA_W-1:0] max_frame_reg;
    logic                       pause_reg;
    logic [LIMIT_W-1:0]         limit_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fixed_step_reg <= '0;
            max_frame_reg  <= '0;
            pause_reg      <= 1'b0;
            limit_reg      <= '0;
        end
        else
        begin
            // The product is registered; the sequencer reads it in S_CHECK, after the S_MUL state.
            limit_reg <= LIMIT_W'(fixed_step_reg) * LIMIT_W'(STEP_LIMIT);
            if (cfg_we)
            begin
                case (cfg_index)
                    fta_pkg::CFG_FIXED_STEP: fixed_step_reg <= cfg_data;
                    fta_pkg::CFG_MAX_FRAME:  max_frame_reg  <= cfg_data;
                    fta_pkg::CFG_PAUSE:      pause_reg      <= cfg_data[0];
                    default:                 ;
                endcase
            end
        end
    end

    always_comb
    begin
        cfg.fixed_step = fixed_step_reg;
        cfg.max_frame  = max_frame_reg;
        cfg.pause      = pause_reg;
        cfg.ok         = (fixed_step_reg != '0) && (max_frame_reg >= fixed_step_reg)
                         && (LIMIT_W'(max_frame_reg) <= limit_reg);
    end

endmodule

### src/fta_divu.sv
// Restoring divider datapath built around one shared subtractor.
module fta_divu (
    input  logic                       clk,
    input  logic [fta_pkg::DATA_W-1:0] divisor,
    input  fta_pkg::divu_cmd_t         cmd,
    output fta_pkg::divu_stat_t        stat
);

    logic [fta_pkg::DATA_W-1:0] rem_reg;
    logic [fta_pkg::QUO_W-1:0]  quo_reg;
    logic                       ge_reg;

    logic [fta_pkg::QUO_W-1:0]  trial;
    logic [fta_pkg::QUO_W:0]    diff;
    logic                       borrow;

    // A compare tests the remainder as it stands; an iteration shifts in the next bit.
    always_comb
    begin
        trial  = cmd.compare ? {1'b0, rem_reg} : {rem_reg, quo_reg[fta_pkg::QUO_W-1]};
        diff   = {1'b0, trial} - {2'b00, divisor};
        borrow = diff[fta_pkg::QUO_W];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            rem_reg <= cmd.load_rem;
            quo_reg <= cmd.load_quo;
        end
        else if (cmd.compare)
        begin
            ge_reg  <= ~borrow;
            quo_reg <= '0;
        end
        else if (cmd.iterate)
        begin
            rem_reg <= borrow ? trial[fta_pkg::DATA_W-1:0] : diff[fta_pkg::DATA_W-1:0];
            quo_reg <= {quo_reg[fta_pkg::QUO_W-2:0], ~borrow};
        end
    end

    assign stat.rem = rem_reg;
    assign stat.quo = quo_reg;
    assign stat.ge  = ge_reg;

endmodule

### src/fixed_timestep_accumulator.sv
// Top level of the fixed timestep accumulator: sequencer, state and output register.
//
// Usage. One input word per rendered frame arrives on the in_valid/in_ready channel with
// a mode and a signed Q11.20 frame time. Each input word produces exactly one result word
// on the out_valid/out_ready channel: the number of fixed steps to run, alpha (the
// remaining fraction of a step, Q0.16) and the configuration status. The step length,
// the largest frame time and the pause flag are written through the cfg_we port; the
// user must write them only while the block is idle, as the block does not enforce it.
//
// Timing. An advance goes from acceptance through the set-up states S_MUL and S_CHECK,
// the iterations of the shared subtractor for the step count in S_DIV, one compare in
// S_CMP and the iterations for alpha in S_FRAC, then S_DONE loads the output register.
// Other modes and paused advances skip the step count, and alpha stops early when it
// saturates; with an invalid configuration an item goes from S_CHECK to S_DONE. in_ready
// stays low meanwhile and returns in the cycle after the load: one word at a time.
//
// Reset clears the configuration, the accumulator and the queued single step, and leaves
// no result pending. When the receiver stalls, the finished result waits in the output
// register; the block still takes the next input word and holds its own result in the
// final state until the output register is free.
module fixed_timestep_accumulator #(
    parameter int STEP_LIMIT = 4096
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic [1:0]                   mode,
    input  logic signed [31:0]           frame_time,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic [fta_pkg::STEPS_W-1:0]  steps,
    output logic [fta_pkg::ALPHA_W-1:0]  alpha,
    output logic                         config_ok,
    input  logic                         cfg_we,
    input  logic [1:0]                   cfg_index,
    input  logic [fta_pkg::DATA_W-1:0]   cfg_data
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_MUL   = 3'd1;
    localparam logic [2:0] S_CHECK = 3'd2;
    localparam logic [2:0] S_DIV   = 3'd3;
    localparam logic [2:0] S_CMP   = 3'd4;
    localparam logic [2:0] S_FRAC  = 3'd5;
    localparam logic [2:0] S_DONE  = 3'd6;

    fta_pkg::cfg_t       cfg;
    fta_pkg::divu_cmd_t  cmd;
    fta_pkg::divu_stat_t stat;

    logic [2:0]                       state_reg, state_next;
    logic [fta_pkg::CNT_W-1:0]        cnt_reg, cnt_next;
    logic [1:0]                       mode_reg;
    logic [fta_pkg::DATA_W-1:0]       frame_reg;
    logic [fta_pkg::DATA_W-1:0]       remainder_reg, remainder_next;
    logic                             pending_reg, pending_next;
    logic [fta_pkg::STEPS_W-1:0]      steps_reg, steps_next;
    logic                             ok_reg, ok_next;
    logic                             out_valid_reg, out_valid_next;
    logic [fta_pkg::STEPS_W-1:0]      out_steps_reg;
    logic [fta_pkg::ALPHA_W-1:0]      out_alpha_reg;
    logic                             out_ok_reg;
    logic                             out_load;

    logic [fta_pkg::DATA_W-1:0]       clamped;
    logic [fta_pkg::QUO_W-1:0]        sum;
    logic [fta_pkg::ALPHA_W-1:0]      alpha_final;

    fta_cfg #(
        .STEP_LIMIT (STEP_LIMIT)
    ) u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    fta_divu u_divu (
        .clk     (clk),
        .divisor (cfg.fixed_step),
        .cmd     (cmd),
        .stat    (stat)
    );

    assign in_ready = (state_reg == S_IDLE);

    // Negative frame times count as zero; long frames are cut to the largest frame time.
    always_comb
    begin
        if (frame_reg[fta_pkg::DATA_W-1])
        begin
            clamped = '0;
        end
        else if (frame_reg > cfg.max_frame)
        begin
            clamped = cfg.max_frame;
        end
        else
        begin
            clamped = frame_reg;
        end
        sum = {1'b0, remainder_reg} + {1'b0, clamped};
    end

    // Alpha is zero for a bad configuration and saturates if the remainder is a step or more.
    always_comb
    begin
        if (!ok_reg)
        begin
            alpha_final = '0;
        end
        else if (stat.ge)
        begin
            alpha_final = fta_pkg::ALPHA_MAX;
        end
        else
        begin
            alpha_final = stat.quo[fta_pkg::ALPHA_W-1:0];
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        remainder_next = remainder_reg;
        pending_next   = pending_reg;
        steps_next     = steps_reg;
        ok_next        = ok_reg;
        out_load       = 1'b0;
        cmd.load       = 1'b0;
        cmd.iterate    = 1'b0;
        cmd.compare    = 1'b0;
        cmd.load_rem   = remainder_reg;
        cmd.load_quo   = '0;

        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = S_MUL;
                end
            end
            S_MUL:
            begin
                state_next = S_CHECK;
            end
            S_CHECK:
            begin
                ok_next    = cfg.ok;
                steps_next = '0;
                cmd.load   = 1'b1;
                state_next = cfg.ok ? S_CMP : S_DONE;
                case (mode_reg)
                    fta_pkg::MODE_ADVANCE:
                    begin
                        if (cfg.ok && cfg.pause)
                        begin
                            steps_next   = fta_pkg::STEPS_W'(pending_reg);
                            pending_next = 1'b0;
                        end
                        else if (cfg.ok)
                        begin
                            cmd.load_rem = '0;
                            cmd.load_quo = sum;
                            cnt_next     = fta_pkg::CNT_W'(fta_pkg::DIV_STEPS - 1);
                            state_next   = S_DIV;
                        end
                    end
                    fta_pkg::MODE_QUEUE:
                    begin
                        if (cfg.pause)
                        begin
                            pending_next = 1'b1;
                        end
                    end
                    fta_pkg::MODE_CLEAR:
                    begin
                        remainder_next = '0;
                        pending_next   = 1'b0;
                        cmd.load_rem   = '0;
                    end
                    default:
                    begin
                    end
                endcase
            end
            S_DIV:
            begin
                cmd.iterate = 1'b1;
                cnt_next    = cnt_reg - fta_pkg::CNT_W'(1);
                if (cnt_reg == '0)
                begin
                    state_next = S_CMP;
                end
            end
            S_CMP:
            begin
                // After a full advance the divider holds the new remainder and quotient.
                if (mode_reg == fta_pkg::MODE_ADVANCE && !cfg.pause)
                begin
                    remainder_next = stat.rem;
                    steps_next     = (|stat.quo[fta_pkg::QUO_W-1:fta_pkg::STEPS_W])
                                     ? fta_pkg::STEPS_MAX
                                     : stat.quo[fta_pkg::STEPS_W-1:0];
                end
                cmd.compare = 1'b1;
                cnt_next    = fta_pkg::CNT_W'(fta_pkg::FRAC_STEPS - 1);
                state_next  = S_FRAC;
            end
            S_FRAC:
            begin
                if (stat.ge)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    cmd.iterate = 1'b1;
                    cnt_next    = cnt_reg - fta_pkg::CNT_W'(1);
                    if (cnt_reg == '0)
                    begin
                        state_next = S_DONE;
                    end
                end
            end
            S_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_load   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cnt_reg       <= '0;
            remainder_reg <= '0;
            pending_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            remainder_reg <= remainder_next;
            pending_reg   <= pending_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            mode_reg  <= mode;
            frame_reg <= frame_time;
        end
        steps_reg <= steps_next;
        ok_reg    <= ok_next;
        if (out_load)
        begin
            out_steps_reg <= steps_reg;
            out_alpha_reg <= alpha_final;
            out_ok_reg    <= ok_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign steps     = out_steps_reg;
    assign alpha     = out_alpha_reg;
    assign config_ok = out_ok_reg;

endmodule

### src/fta_chk.sv
// Port-level assertions for the fixed timestep accumulator, bound to the top level.
module fta_chk (
    input logic                        clk,
    input logic                        rst_n,
    input logic                        in_valid,
    input logic                        in_ready,
    input logic                        out_valid,
    input logic                        out_ready,
    input logic [fta_pkg::STEPS_W-1:0] steps,
    input logic [fta_pkg::ALPHA_W-1:0] alpha,
    input logic                        config_ok
);

    // A stalled result word keeps its contents.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(steps) && $stable(alpha)
                                    && $stable(config_ok))
        else $error("result word changed while stalled");

    // The block works on one word at a time.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("input taken while a word is in progress");

    // Steps are only reported under a valid configuration.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && steps != '0 |-> config_ok)
        else $error("steps reported with invalid configuration");

    // Alpha is zero whenever the configuration is invalid.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !config_ok |-> alpha == '0)
        else $error("alpha non-zero with invalid configuration");

endmodule

bind fixed_timestep_accumulator fta_chk u_fta_chk (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .steps     (steps),
    .alpha     (alpha),
    .config_ok (config_ok)
);

### verif/tb.sv
// Self-checking testbench for the fixed timestep accumulator, directed words then random phases.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int STEP_LIMIT = 4096;
    // Mode 3 is unused by the block. It must act as a no-operation that still reports alpha.
    localparam logic [1:0] MODE_UNUSED = 2'd3;
    // The slowest legal stretch without any handshake is a long sender gap, one advance
    // and a long receiver stall. The limit is taken many times over that.
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int SETTLE_CYCLES = 120;
    localparam int RANDOM_PHASES = 13;
    localparam int PHASE_WORDS = 98;

    typedef struct packed {
        logic [1:0]  mode;
        logic [31:0] frame_time;
        logic        drain_first;
    } frame_word_t;

    typedef struct packed {
        logic [fta_pkg::STEPS_W-1:0] steps;
        logic [fta_pkg::ALPHA_W-1:0] alpha;
        logic                        ok;
    } step_result_t;

    logic                         clk = 1'b0;
    logic                         rst_n = 1'b0;
    logic                         in_valid = 1'b0;
    logic                         in_ready;
    logic [1:0]                   mode = fta_pkg::MODE_ADVANCE;
    logic signed [31:0]           frame_time = '0;
    logic                         out_valid;
    logic                         out_ready = 1'b0;
    logic [fta_pkg::STEPS_W-1:0]  steps;
    logic [fta_pkg::ALPHA_W-1:0]  alpha;
    logic                         config_ok;
    logic                         cfg_we = 1'b0;
    logic [1:0]                   cfg_index = fta_pkg::CFG_FIXED_STEP;
    logic [fta_pkg::DATA_W-1:0]   cfg_data = '0;

    fixed_timestep_accumulator #(
        .STEP_LIMIT(STEP_LIMIT)
    ) u_top (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_ready(in_ready),
        .mode(mode),
        .frame_time(frame_time),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .steps(steps),
        .alpha(alpha),
        .config_ok(config_ok),
        .cfg_we(cfg_we),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    // Our own copy of the register file, as last written through the write port.
    logic [31:0] step_len = '0;
    logic [31:0] frame_cap = '0;
    logic        paused = 1'b0;
    // Our own copy of the accumulator state, both cleared by reset.
    logic [31:0] acc_rem = '0;
    logic        step_armed = 1'b0;

    frame_word_t  frames_to_send[$];
    step_result_t results_due[$];
    frame_word_t  next_frame;
    step_result_t due;

    int unsigned fail_count = 0;
    int unsigned send_gap = 0;
    int unsigned stall_left = 0;
    int unsigned idle_cycles = 0;
    bit          word_taken = 1'b0;
    // While steady is set neither side idles, so words go through back to back.
    bit          steady = 1'b0;

    initial begin
        forever #10 clk = ~clk;
    end

    // The configuration is only usable when the step is non-zero, the largest frame covers
    // at least one step and no more than STEP_LIMIT steps.
    function automatic bit setting_valid();
        return step_len != 32'd0 && frame_cap >= step_len &&
               {32'd0, frame_cap} <= 64'(step_len) * 64'(STEP_LIMIT);
    endfunction

    // Applies one accepted word to the predictor state and returns the result it must give.
    function automatic step_result_t account_frame(input logic [1:0] m, input logic [31:0] ft);
        step_result_t r;
        logic [31:0]  taken;
        logic [32:0]  total;
        logic [32:0]  whole;
        logic [47:0]  frac;
        bit           ok;
        ok = setting_valid();
        r.steps = '0;
        case (m)
            fta_pkg::MODE_ADVANCE:
            begin
                if (ok && paused)
                begin
                    // A paused advance only releases a queued single step.
                    r.steps = fta_pkg::STEPS_W'(step_armed);
                    step_armed = 1'b0;
                end
                else if (ok)
                begin
                    // Negative frame times count as zero, long ones are cut to the cap.
                    taken = ft[31] ? 32'd0 : ft;
                    if (taken > frame_cap)
                        taken = frame_cap;
                    total = {1'b0, acc_rem} + {1'b0, taken};
                    whole = total / {1'b0, step_len};
                    acc_rem = 32'(total % {1'b0, step_len});
                    // Only a step shortened under a large remainder can push this past the
                    // output width; the count then saturates while the accumulator drains.
                    r.steps = (whole > 33'(fta_pkg::STEPS_MAX)) ? fta_pkg::STEPS_MAX
                                                                 : whole[fta_pkg::STEPS_W-1:0];
                end
            end
            fta_pkg::MODE_QUEUE:
            begin
                if (paused)
                    step_armed = 1'b1;
            end
            fta_pkg::MODE_CLEAR:
            begin
                acc_rem = '0;
                step_armed = 1'b0;
            end
            default:
            begin
            end
        endcase
        frac = '0;
        if (ok)
            frac = {acc_rem, 16'd0} / {16'd0, step_len};
        r.alpha = (frac > 48'(fta_pkg::ALPHA_MAX)) ? fta_pkg::ALPHA_MAX
                                                    : frac[fta_pkg::ALPHA_W-1:0];
        r.ok = ok;
        return r;
    endfunction

    // Mostly no gap, often a short one, now and then a long one.
    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (steady || r < 55)
            return 0;
        if (r < 85)
            return $urandom_range(1, 4);
        if (r < 97)
            return $urandom_range(5, 30);
        return $urandom_range(60, 200);
    endfunction

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            fail_count++;
        end
    endtask

    task automatic queue_item(input logic [1:0] m, input logic [31:0] ft, input bit drain);
        frame_word_t w;
        w.mode = m;
        w.frame_time = ft;
        w.drain_first = drain;
        frames_to_send.push_back(w);
    endtask

    // Returns once every queued word has been taken and every result word has come back.
    // As each word yields exactly one result, the block is then idle as well.
    task automatic wait_idle();
        @(posedge clk);
        while (frames_to_send.size() != 0 || in_valid || results_due.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [31:0] value);
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        @(negedge clk);
        cfg_we <= 1'b0;
        case (idx)
            fta_pkg::CFG_FIXED_STEP: step_len = value;
            fta_pkg::CFG_MAX_FRAME:  frame_cap = value;
            default:                 paused = value[0];
        endcase
    endtask

    task automatic set_config(input logic [31:0] step_v, input logic [31:0] cap_v,
                              input bit pause_v);
        wait_idle();
        write_reg(fta_pkg::CFG_FIXED_STEP, step_v);
        write_reg(fta_pkg::CFG_MAX_FRAME, cap_v);
        write_reg(fta_pkg::CFG_PAUSE, {31'd0, pause_v});
    endtask

    // Sender and receiver both change their signals on the falling edge, away from the
    // rising edge at which the block samples them.
    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            out_ready <= 1'b0;
        end
        else
        begin
            // A presented word is held until the rising edge has taken it.
            if (!in_valid || word_taken)
            begin
                word_taken = 1'b0;
                if (send_gap > 0)
                begin
                    in_valid <= 1'b0;
                    send_gap--;
                end
                else if (frames_to_send.size() > 0 &&
                         !(frames_to_send[0].drain_first && results_due.size() > 0))
                begin
                    // A word marked drain_first waits until all earlier results are back.
                    next_frame = frames_to_send.pop_front();
                    in_valid <= 1'b1;
                    mode <= next_frame.mode;
                    frame_time <= next_frame.frame_time;
                    send_gap = pick_gap();
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end

            // The receiver stalls independently of out_valid, so stalls land on every
            // phase of the block's work, including while it already holds a result.
            if (stall_left > 0)
            begin
                out_ready <= 1'b0;
                stall_left--;
            end
            else
            begin
                out_ready <= 1'b1;
                if (!steady && $urandom_range(0, 99) < 30)
                    stall_left = pick_gap();
            end
        end
    end

    // Everything is sampled on the rising edge. Results are checked before the word taken
    // at the same edge is predicted, since that word's result can only come later.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && out_ready)
            begin
                if (results_due.size() == 0)
                begin
                    $error("result word with none expected: steps %0d alpha %0d config_ok %0d",
                           steps, alpha, config_ok);
                    fail_count++;
                end
                else
                begin
                    due = results_due.pop_front();
                    check_field("steps", 32'(due.steps), 32'(steps));
                    check_field("alpha", 32'(due.alpha), 32'(alpha));
                    check_field("config_ok", 32'(due.ok), 32'(config_ok));
                end
            end
            if (in_valid && in_ready)
            begin
                results_due.push_back(account_frame(mode, frame_time));
                word_taken = 1'b1;
            end

            // The watchdog only counts cycles in which no handshake or write took place.
            if ((in_valid && in_ready) || (out_valid && out_ready) || cfg_we)
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("simulation failed");
                $finish;
            end
        end
    end

    initial
    begin
        logic [31:0] step_v;
        logic [63:0] cap_v;
        logic [63:0] wide;
        logic [31:0] span;
        logic [31:0] ft;
        logic [1:0]  m;
        int unsigned r;

        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Straight out of reset the step is zero, so every mode reports an invalid setting.
        // The first word also waits for an empty pipeline, which exercises the drain pause.
        queue_item(fta_pkg::MODE_ADVANCE, 32'h0010_0000, 1'b1);
        queue_item(fta_pkg::MODE_QUEUE, 32'h0000_0000, 1'b0);
        queue_item(fta_pkg::MODE_CLEAR, 32'hFFFF_FFFF, 1'b0);
        queue_item(MODE_UNUSED, 32'h1234_5678, 1'b0);

        // One second per step, at most 64 steps per frame.
        set_config(32'h0010_0000, 32'h0400_0000, 1'b0);
        queue_item(fta_pkg::MODE_ADVANCE, 32'h7FFF_FFFF, 1'b0);   // clamped to the cap
        queue_item(fta_pkg::MODE_ADVANCE, 32'h8000_0000, 1'b0);   // most negative time
        queue_item(fta_pkg::MODE_ADVANCE, 32'hFFFF_FFFF, 1'b0);   // minus one
        queue_item(fta_pkg::MODE_ADVANCE, 32'h0008_0000, 1'b0);   // half a step left over
        queue_item(fta_pkg::MODE_ADVANCE, 32'h0008_0000, 1'b0);   // completes a step
        queue_item(fta_pkg::MODE_QUEUE, 32'h0000_0000, 1'b0);     // ignored while running
        queue_item(fta_pkg::MODE_ADVANCE, 32'h0004_0000, 1'b0);
        queue_item(fta_pkg::MODE_CLEAR, 32'h0000_0000, 1'b0);
        queue_item(MODE_UNUSED, 32'h0000_0000, 1'b0);

        // Paused: advances release at most one queued step, and a clear drops the queue.
        set_config(32'h0010_0000, 32'h0400_0000, 1'b1);
        queue_item(fta_pkg::MODE_ADVANCE, 32'h0010_0000, 1'b0);
        queue_item(fta_pkg::MODE_QUEUE, 32'h0000_0000, 1'b0);
        queue_item(fta_pkg::MODE_ADVANCE, 32'h0010_0000, 1'b0);
        queue_item(fta_pkg::MODE_ADVANCE, 32'h0010_0000, 1'b0);
        queue_item(fta_pkg::MODE_QUEUE, 32'h0000_0000, 1'b0);
        queue_item(fta_pkg::MODE_CLEAR, 32'h0000_0000, 1'b0);
        queue_item(fta_pkg::MODE_ADVANCE, 32'h0010_0000, 1'b0);

        // Leave a remainder of one unit short of a large step, then shorten the step so the
        // remainder exceeds it: alpha and the step count must both saturate.
        set_config(32'h0100_0000, 32'h1000_0000, 1'b0);
        queue_item(fta_pkg::MODE_ADVANCE, 32'h00FF_FFFF, 1'b0);
        set_config(32'h0000_0001, 32'h0000_0001, 1'b0);
        queue_item(MODE_UNUSED, 32'h0000_0000, 1'b0);
        queue_item(fta_pkg::MODE_ADVANCE, 32'h0000_0000, 1'b0);

        // One past the step ratio limit, and a cap below the step, are both invalid.
        set_config(32'h0000_0001, 32'd4097, 1'b0);
        queue_item(fta_pkg::MODE_ADVANCE, 32'h0000_0005, 1'b0);
        set_config(32'h0000_0005, 32'h0000_0004, 1'b0);
        queue_item(fta_pkg::MODE_ADVANCE, 32'h0000_0005, 1'b0);

        // Largest step and cap, then a cap of exactly STEP_LIMIT steps.
        set_config(32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0);
        queue_item(fta_pkg::MODE_ADVANCE, 32'h7FFF_FFFF, 1'b0);
        queue_item(fta_pkg::MODE_ADVANCE, 32'h7FFF_FFFF, 1'b0);
        set_config(32'h0000_0010, 32'h0001_0000, 1'b0);
        queue_item(fta_pkg::MODE_ADVANCE, 32'h7FFF_FFFF, 1'b0);

        // Random phases: a fresh setting each time, mostly valid with a bias towards few
        // steps per frame, followed by a batch of words whose times suit that setting.
        for (int p = 0; p < RANDOM_PHASES; p++)
        begin
            r = $urandom_range(0, 19);
            if (r < 6)
                step_v = $urandom_range(1, 64);
            else if (r < 13)
                step_v = $urandom_range(32'h0000_1000, 32'h0020_0000);
            else if (r < 18)
                step_v = $urandom();
            else if (r < 19)
                step_v = 32'h0000_4444;   // roughly a sixtieth of a second
            else
                step_v = 32'd0;
            r = $urandom_range(0, 9);
            if (r < 5)
                cap_v = 64'(step_v) * 64'($urandom_range(1, 8));
            else if (r < 7)
                cap_v = 64'(step_v) * 64'($urandom_range(1, 256));
            else if (r < 8)
                cap_v = 64'(step_v) * 64'($urandom_range(1, STEP_LIMIT));
            else if (r < 9)
                cap_v = 64'(step_v) * 64'(STEP_LIMIT + 1);
            else
                cap_v = 64'($urandom());
            if (cap_v > 64'h0000_0000_FFFF_FFFF)
                cap_v = 64'h0000_0000_FFFF_FFFF;
            set_config(step_v, cap_v[31:0], $urandom_range(0, 3) == 0);
            steady = ($urandom_range(0, 4) == 0);

            span = (frame_cap > 32'h7FFF_FFFF) ? 32'h7FFF_FFFF : frame_cap;
            for (int i = 0; i < PHASE_WORDS; i++)
            begin
                r = $urandom_range(0, 99);
                if (paused)
                    m = (r < 50) ? fta_pkg::MODE_ADVANCE : (r < 85) ? fta_pkg::MODE_QUEUE :
                        (r < 94) ? fta_pkg::MODE_CLEAR : MODE_UNUSED;
                else
                    m = (r < 80) ? fta_pkg::MODE_ADVANCE : (r < 88) ? fta_pkg::MODE_QUEUE :
                        (r < 95) ? fta_pkg::MODE_CLEAR : MODE_UNUSED;
                r = $urandom_range(0, 99);
                if (r < 45)
                    ft = $urandom_range(0, span);
                else if (r < 65)
                begin
                    // A few steps plus a fraction, so remainders carry between frames.
                    wide = 64'(step_len) * 64'($urandom_range(0, 3)) +
                           64'($urandom_range(0, step_len));
                    ft = (wide > 64'(span)) ? span : wide[31:0];
                end
                else if (r < 75)
                    ft = span + $urandom_range(0, 3);
                else if (r < 90)
                    ft = $urandom();
                else
                    ft = 32'd0 - $urandom_range(1, 32'h0010_0000);
                queue_item(m, ft, $urandom_range(0, 99) < 2);
            end
        end

        wait_idle();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (fail_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
